>>> rtl/lph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lph_pkg
// Types and constants shared by the linear probing hash table.
// ----------------------------------------------------------------------------
package lph_pkg;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  // Mixing multiplier; only the low 32 product bits reach the slot index.
  localparam logic [31:0] MIX_MUL = 32'h045d_9f3b;

  localparam int unsigned KEY_W = 64;
  localparam int unsigned VAL_W = 24;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lph_in_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value_out;
    logic             table_full;
  } lph_out_t;

endpackage

>>> rtl/lph_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lph_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lph_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/linear_probe_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open addressing key/value store, linear probing with wrap-around.
// ----------------------------------------------------------------------------
// Flow: an accepted input beat passes S_ADDR, then S_CHECK for each of the n
//   slots probed (1 to SLOTS), one probe per cycle, set by the single read port
//   of the slot RAMs, then S_DONE, which registers the result for out_valid_o.
// Input is stalled from the accepted beat until S_DONE hands off its result.
// Reset: a clearing pass over every slot zeroes the valid RAM; input is stalled
//   meanwhile. Key and value RAMs are not cleared.
module linear_probe_hash_table import lph_pkg::*; #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  lph_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output lph_out_t out_data_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_CHECK,
    S_DONE
  } state_e;

  state_e           state_q;
  logic [IW-1:0]    clr_q;
  logic [IW-1:0]    idx_q;
  logic [IW-1:0]    cnt_q;
  logic [31:0]      prod_q;
  logic             mode_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  lph_out_t         res_q;
  logic             out_valid_q;
  lph_out_t         out_data_q;

  logic [31:0]      mix_d;
  logic [31:0]      prod_d;
  logic [IW-1:0]    home;
  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  logic             vld_rd;
  logic [KEY_W-1:0] key_rd;
  logic [VAL_W-1:0] val_rd;
  logic             hit;
  logic             stop;
  logic             vld_we;
  logic [IW-1:0]    vld_waddr;
  logic             vld_wdata;
  logic             data_we;
  logic             out_free;

  // key >> 3, xor-shift 16; only the low 32 bits feed the low product bits
  assign mix_d  = in_data_i.key[34:3] ^ in_data_i.key[50:19];
  assign prod_d = mix_d * MIX_MUL;
  assign home   = prod_q[IW-1:0] ^ prod_q[IW+15:16];

  assign hit  = vld_rd && (key_rd == key_q);
  assign stop = !vld_rd || hit;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = home;
    case (state_q)
      S_ADDR: begin
        rd_en   = 1'b1;
        rd_addr = home;
      end
      S_CHECK: begin
        rd_en   = !stop && (cnt_q != LAST_IDX);
        rd_addr = idx_q + IW'(1);
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = home;
      end
    endcase
  end

  assign data_we   = (state_q == S_CHECK) && stop && (mode_q == MODE_INSERT);
  assign vld_we    = data_we || (state_q == S_CLEAR);
  assign vld_waddr = (state_q == S_CLEAR) ? clr_q : idx_q;
  assign vld_wdata = (state_q != S_CLEAR);

  lph_ram #(
    .WIDTH (1),
    .DEPTH (SLOTS)
  ) u_vld_ram (
    .clk_i   (clk_i),
    .we_i    (vld_we),
    .waddr_i (vld_waddr),
    .wdata_i (vld_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (vld_rd)
  );

  lph_ram #(
    .WIDTH (KEY_W + VAL_W),
    .DEPTH (SLOTS)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (idx_q),
    .wdata_i ({key_q, val_q}),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o ({key_rd, val_rd})
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + IW'(1);
          if (clr_q == LAST_IDX) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            mode_q  <= in_data_i.mode;
            key_q   <= in_data_i.key;
            val_q   <= in_data_i.value;
            prod_q  <= prod_d;
            state_q <= S_ADDR;
          end
        end
        S_ADDR: begin
          idx_q   <= home;
          cnt_q   <= '0;
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (stop) begin
            res_q.found      <= hit;
            res_q.value_out  <= (hit && (mode_q == MODE_LOOKUP)) ? val_rd : '0;
            res_q.table_full <= 1'b0;
            state_q          <= S_DONE;
          end else if (cnt_q == LAST_IDX) begin
            // wrapped all the way round without an empty slot or the key
            res_q.found      <= 1'b0;
            res_q.value_out  <= '0;
            res_q.table_full <= (mode_q == MODE_INSERT);
            state_q          <= S_DONE;
          end else begin
            idx_q <= idx_q + IW'(1);
            cnt_q <= cnt_q + IW'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data_q  <= res_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A full-table result never also claims a hit or carries a value.
  a_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.table_full &&
                      (out_data_o.found || (out_data_o.value_out != '0))))
    else $error("table_full together with found or value");

  // Slot data is written only by an insert that stopped on a probe.
  a_we_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_we |-> (state_q == S_CHECK) && (mode_q == MODE_INSERT))
    else $error("slot write outside an insert probe");

  // An accepted beat always starts the hash/address step.
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_ADDR))
    else $error("accepted beat did not start a probe");

  // Probing ends at the last slot of the wrap.
  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_CHECK) && (cnt_q == LAST_IDX)) |=> (state_q == S_DONE))
    else $error("probe ran past the table size");

endmodule

>>> sim/lph_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lph_table_checker
// Watches both channels of the hash table, keeps its own copy of the slot
// arrays, predicts every result beat when the request beat is accepted and
// compares each result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lph_table_checker import lph_pkg::*; #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  lph_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  lph_out_t    out_data_i,
  output int unsigned err_count_o,
  output int unsigned pending_o,
  output int unsigned fill_o,
  output int unsigned results_o,
  output int unsigned hits_o,
  output int unsigned overwrites_o,
  output int unsigned refused_o
);

  localparam logic [63:0] MIX_MUL_FULL = 64'h0000_0000_045d_9f3b;

  bit               slot_used [SLOTS];
  logic [KEY_W-1:0] slot_key  [SLOTS];
  logic [VAL_W-1:0] slot_val  [SLOTS];
  lph_out_t         expected_results [$];

  // Home slot: drop the three alignment bits, xor-shift, wrapping multiply,
  // xor-shift again.
  function automatic int unsigned slot_of(logic [KEY_W-1:0] key);
    logic [63:0] h;
    h = key >> 3;
    h = h ^ (h >> 16);
    h = h * MIX_MUL_FULL;
    h = h ^ (h >> 16);
    return h[31:0] & (SLOTS - 1);
  endfunction

  // Walks the probe chain and applies an insert to the local table copy.
  function automatic lph_out_t probe_table(lph_in_t req);
    lph_out_t    res;
    int unsigned idx;
    int unsigned n;
    bit          done;
    res  = '0;
    idx  = slot_of(req.key);
    done = 1'b0;
    for (n = 0; n < SLOTS && !done; n++) begin
      if (!slot_used[idx]) begin
        if (req.mode == MODE_INSERT) begin
          slot_used[idx] = 1'b1;
          slot_key[idx]  = req.key;
          slot_val[idx]  = req.value;
          fill_o++;
        end
        done = 1'b1;
      end else if (slot_key[idx] == req.key) begin
        res.found = 1'b1;
        if (req.mode == MODE_INSERT) begin
          slot_val[idx] = req.value;
        end else begin
          res.value_out = slot_val[idx];
        end
        done = 1'b1;
      end
      idx = (idx + 1) & (SLOTS - 1);
    end
    if (!done && req.mode == MODE_INSERT) res.table_full = 1'b1;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lph_out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
      expected_results.delete();
      err_count_o  = 0;
      pending_o    = 0;
      fill_o       = 0;
      results_o    = 0;
      hits_o       = 0;
      overwrites_o = 0;
      refused_o    = 0;
    end else begin
      // pop before push: a result beat never belongs to a request of the same edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          err_count_o++;
          $display("%0t: unexpected result beat, expected none, got found %0d value %06h full %0d",
                   $time, out_data_i.found, out_data_i.value_out, out_data_i.table_full);
        end else begin
          want = expected_results.pop_front();
          results_o++;
          if (out_data_i.found !== want.found) begin
            err_count_o++;
            $display("%0t: found mismatch, expected %0d, got %0d",
                     $time, want.found, out_data_i.found);
          end
          if (out_data_i.value_out !== want.value_out) begin
            err_count_o++;
            $display("%0t: value_out mismatch, expected %06h, got %06h",
                     $time, want.value_out, out_data_i.value_out);
          end
          if (out_data_i.table_full !== want.table_full) begin
            err_count_o++;
            $display("%0t: table_full mismatch, expected %0d, got %0d",
                     $time, want.table_full, out_data_i.table_full);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = probe_table(in_data_i);
        if (want.found && in_data_i.mode == MODE_LOOKUP) hits_o++;
        if (want.found && in_data_i.mode == MODE_INSERT) overwrites_o++;
        if (want.table_full) refused_o++;
        expected_results.push_back(want);
      end
      pending_o = expected_results.size();
    end
  end

endmodule

>>> sim/tb_linear_probe_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table
// Drives lookups and inserts into the hash table: a directed set covering
// empty-table misses, overwrites, collision chains and wrap-around, random
// traffic over a clustered key pool under four pacing schemes, then a fill
// to capacity with refused inserts and misses on the full table.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table;
  import lph_pkg::*;

  localparam int unsigned SLOTS       = 1024;
  localparam int unsigned POOL_SIZE   = 64;
  localparam int unsigned RAND_ITEMS  = 800;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned QUIET_LIMIT = 20000;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  lph_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  lph_out_t    out_data;

  int unsigned err_count;
  int unsigned pending;
  int unsigned fill_level;
  int unsigned n_results;
  int unsigned n_hits;
  int unsigned n_overwrites;
  int unsigned n_refused;
  int unsigned quiet_cycles;

  idle_mode_e  idle_mode = IDLE_NONE;
  bit          hold_armed = 1'b0;
  bit          hold_done = 1'b0;
  logic [63:0] key_pool [POOL_SIZE];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  linear_probe_hash_table #(.SLOTS(SLOTS)) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  lph_table_checker #(.SLOTS(SLOTS)) u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .err_count_o  (err_count),
    .pending_o    (pending),
    .fill_o       (fill_level),
    .results_o    (n_results),
    .hits_o       (n_hits),
    .overwrites_o (n_overwrites),
    .refused_o    (n_refused)
  );

  function automatic bit roll(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic bit sender_rests();
    case (idle_mode)
      IDLE_SENDER: return roll(81);
      IDLE_BOTH:   return roll(22);
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: return roll(81);
      IDLE_BOTH:     return roll(22);
      default:       return 1'b0;
    endcase
  endfunction

  // Valid stays high from one beat to the next unless a gap is rolled.
  task automatic push_request(input logic mode, input logic [63:0] key,
                              input logic [23:0] value);
    lph_in_t req;
    req.mode  = mode;
    req.key   = key;
    req.value = value;
    while (sender_rests()) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Mostly pool keys with the alignment bits varied, so chains form and hit.
  task automatic push_random();
    logic [63:0] key;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    key  = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (pick < 70) key[2:0] = 3'($urandom_range(0, 7));
    else if (pick >= 90) key = {$urandom, $urandom};
    push_request(1'($urandom_range(0, 1)), key, 24'($urandom));
  endtask

  // Result side: one long hold-off once armed, random stalls otherwise.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_armed && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
      out_stall <= receiver_stalls();
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL linear_probe_hash_table");
      $finish;
    end
  end

  initial begin
    logic [63:0] wrap_key [3];
    rst_ni   <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    // keys homed on the last slot, so their chains wrap to slot 0
    for (int i = 0; i < 3; i++) begin
      do wrap_key[i] = {$urandom, $urandom};
      while (u_chk.slot_of(wrap_key[i]) != SLOTS - 1);
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    push_request(MODE_LOOKUP, 64'h0, 24'h0);
    push_request(MODE_LOOKUP, '1, '1);
    push_request(MODE_INSERT, 64'h0, 24'h0);
    push_request(MODE_INSERT, '1, '1);
    push_request(MODE_LOOKUP, 64'h0, '1);
    push_request(MODE_LOOKUP, '1, 24'h0);
    push_request(MODE_INSERT, 64'h0, 24'h123456);
    push_request(MODE_LOOKUP, 64'h0, 24'h0);
    push_request(MODE_INSERT, 64'h1, 24'haaaaaa);
    push_request(MODE_INSERT, 64'h2, 24'h555555);
    push_request(MODE_LOOKUP, 64'h2, 24'h0);
    push_request(MODE_LOOKUP, 64'h3, 24'h0);
    push_request(MODE_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 24'h555555);
    push_request(MODE_INSERT, 64'h5555_5555_5555_5555, 24'haaaaaa);
    push_request(MODE_LOOKUP, 64'haaaa_aaaa_aaaa_aaaa, 24'h0);
    push_request(MODE_INSERT, wrap_key[0], 24'h000001);
    push_request(MODE_INSERT, wrap_key[1], 24'h800000);
    push_request(MODE_LOOKUP, wrap_key[1], 24'h0);
    push_request(MODE_LOOKUP, wrap_key[2], 24'h0);
    push_request(MODE_INSERT, wrap_key[1], 24'h0);
    push_request(MODE_LOOKUP, wrap_key[1], '1);

    // random traffic, one pacing scheme per quarter
    for (int p = 0; p < 4; p++) begin
      idle_mode = idle_mode_e'(p);
      if (idle_mode == IDLE_NONE) hold_armed = 1'b1;
      repeat (RAND_ITEMS / 4) push_random();
    end

    // fill to capacity, then work on the full table
    idle_mode = IDLE_NONE;
    while (fill_level < SLOTS) push_request(MODE_INSERT, {$urandom, $urandom}, 24'($urandom));
    repeat (4) push_request(MODE_INSERT, {$urandom, $urandom}, 24'($urandom));
    repeat (4) push_request(MODE_LOOKUP, {$urandom, $urandom}, 24'($urandom));
    push_request(MODE_INSERT, 64'h0, 24'hfedcba);
    push_request(MODE_LOOKUP, 64'h0, 24'h0);
    push_request(MODE_INSERT, wrap_key[1], 24'h7fffff);
    push_request(MODE_LOOKUP, wrap_key[1], 24'h0);
    in_valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (SLOTS + 4) @(posedge clk_i);

    $display("Checked %0d results across four pacing schemes and a fill to %0d of %0d slots.",
             n_results, fill_level, SLOTS);
    $display("Lookup hits %0d, overwrites %0d, inserts refused on a full table %0d.",
             n_hits, n_overwrites, n_refused);
    if (err_count == 0 && pending == 0) begin
      $display("PASS linear_probe_hash_table");
    end else begin
      $display("FAIL linear_probe_hash_table");
    end
    $finish;
  end

endmodule
